// File: src/lfu_pkg.sv
package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int TAG_BITS   = 64;

  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 31;
  localparam int SIZE_W   = 63;
  localparam int CAP_W    = 5;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int VC_W   = $clog2(ENTRIES + 1);

  localparam logic [CAP_W-1:0]      CAP_RESET = 5'd16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [KEY_W-1:0]      TAG_MASK  = {KEY_W{1'b1}} >> (KEY_W - TAG_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // one entry as seen through the store's scan read port
  typedef struct packed {
    logic                  valid;
    logic [KEY_W-1:0]      key;
    logic [HANDLE_W-1:0]   handle;
    logic [SIZE_W-1:0]     size;
    logic [COUNT_BITS-1:0] count;
    logic [RANK_W-1:0]     rank;
  } entry_rd_t;

  // accumulated result of one pass over the table
  typedef struct packed {
    logic                  found;
    logic [IDX_W-1:0]      found_idx;
    logic [RANK_W-1:0]     found_rank;
    logic [HANDLE_W-1:0]   found_handle;
    logic [SIZE_W-1:0]     found_size;
    logic                  vict_found;
    logic [IDX_W-1:0]      vict_idx;
    logic [COUNT_BITS-1:0] vict_count;
    logic [RANK_W-1:0]     vict_rank;
    logic [HANDLE_W-1:0]   vict_handle;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
  } scan_t;

  typedef struct packed {
    logic clr;
    logic step;
  } scan_ctl_t;

  // table update applied in the single update cycle
  typedef struct packed {
    logic                en;
    logic                do_hit;
    logic [IDX_W-1:0]    hit_idx;
    logic [RANK_W-1:0]   hit_rank;
    logic                do_evict;
    logic [IDX_W-1:0]    evict_idx;
    logic [RANK_W-1:0]   evict_rank;
    logic                do_insert;
    logic [IDX_W-1:0]    ins_idx;
    logic [KEY_W-1:0]    ins_key;
    logic [HANDLE_W-1:0] ins_handle;
    logic [SIZE_W-1:0]   ins_size;
  } upd_t;

endpackage

// File: src/lfu_store.sv
module lfu_store (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [lfu_pkg::IDX_W-1:0] rd_idx,
  output lfu_pkg::entry_rd_t       rd_entry,
  input  lfu_pkg::upd_t            upd,
  output logic [lfu_pkg::VC_W-1:0] valid_count
);
  import lfu_pkg::*;

  logic                  valid_r   [ENTRIES];
  logic                  valid_nxt [ENTRIES];
  logic [KEY_W-1:0]      key_r     [ENTRIES];
  logic [KEY_W-1:0]      key_nxt   [ENTRIES];
  logic [HANDLE_W-1:0]   handle_r  [ENTRIES];
  logic [HANDLE_W-1:0]   handle_nxt[ENTRIES];
  logic [SIZE_W-1:0]     size_r    [ENTRIES];
  logic [SIZE_W-1:0]     size_nxt  [ENTRIES];
  logic [COUNT_BITS-1:0] count_r   [ENTRIES];
  logic [COUNT_BITS-1:0] count_nxt [ENTRIES];
  logic [RANK_W-1:0]     rank_r    [ENTRIES];
  logic [RANK_W-1:0]     rank_nxt  [ENTRIES];
  logic [VC_W-1:0]       vc_r;
  logic [VC_W-1:0]       vc_nxt;

  assign rd_entry.valid  = valid_r[rd_idx];
  assign rd_entry.key    = key_r[rd_idx];
  assign rd_entry.handle = handle_r[rd_idx];
  assign rd_entry.size   = size_r[rd_idx];
  assign rd_entry.count  = count_r[rd_idx];
  assign rd_entry.rank   = rank_r[rd_idx];
  assign valid_count     = vc_r;

  always_comb begin
    logic [RANK_W-1:0] r1;
    vc_nxt = vc_r;
    for (int j = 0; j < ENTRIES; j++) begin
      valid_nxt[j]  = valid_r[j];
      key_nxt[j]    = key_r[j];
      handle_nxt[j] = handle_r[j];
      size_nxt[j]   = size_r[j];
      count_nxt[j]  = count_r[j];
      rank_nxt[j]   = rank_r[j];
    end
    r1 = '0;
    if (upd.en && upd.do_hit) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (IDX_W'(j) == upd.hit_idx) begin
          rank_nxt[j] = '0;
          if (count_r[j] != COUNT_MAX) begin
            count_nxt[j] = count_r[j] + 1'b1;
          end
        end else if (valid_r[j] && rank_r[j] < upd.hit_rank) begin
          rank_nxt[j] = rank_r[j] + 1'b1;
        end
      end
    end else if (upd.en) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (upd.do_insert && IDX_W'(j) == upd.ins_idx) begin
          valid_nxt[j]  = 1'b1;
          key_nxt[j]    = upd.ins_key;
          handle_nxt[j] = upd.ins_handle;
          size_nxt[j]   = upd.ins_size;
          count_nxt[j]  = COUNT_BITS'(1);
          rank_nxt[j]   = '0;
        end else if (upd.do_evict && IDX_W'(j) == upd.evict_idx) begin
          valid_nxt[j] = 1'b0;
        end else if (valid_r[j]) begin
          // close the gap left by the victim, then age behind the new entry
          r1 = (upd.do_evict && rank_r[j] > upd.evict_rank) ? rank_r[j] - 1'b1 : rank_r[j];
          rank_nxt[j] = upd.do_insert ? r1 + 1'b1 : r1;
        end
      end
      vc_nxt = vc_r - VC_W'(upd.do_evict) + VC_W'(upd.do_insert);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        valid_r[j] <= 1'b0;
      end
    end else begin
      vc_r <= vc_nxt;
      for (int j = 0; j < ENTRIES; j++) begin
        valid_r[j] <= valid_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ENTRIES; j++) begin
      key_r[j]    <= key_nxt[j];
      handle_r[j] <= handle_nxt[j];
      size_r[j]   <= size_nxt[j];
      count_r[j]  <= count_nxt[j];
      rank_r[j]   <= rank_nxt[j];
    end
  end

endmodule

// File: src/lfu_scan.sv
module lfu_scan (
  input  logic                      clk,
  input  lfu_pkg::scan_ctl_t        ctl,
  input  logic [lfu_pkg::IDX_W-1:0] idx,
  input  logic [lfu_pkg::KEY_W-1:0] key,
  input  lfu_pkg::entry_rd_t        ent,
  output lfu_pkg::scan_t            res
);
  import lfu_pkg::*;

  scan_t res_r;
  scan_t res_nxt;

  assign res = res_r;

  always_comb begin
    res_nxt = res_r;
    if (ctl.clr) begin
      res_nxt = '0;
    end else if (ctl.step) begin
      // first match wins
      if (ent.valid && ent.key == key && !res_r.found) begin
        res_nxt.found        = 1'b1;
        res_nxt.found_idx    = idx;
        res_nxt.found_rank   = ent.rank;
        res_nxt.found_handle = ent.handle;
        res_nxt.found_size   = ent.size;
      end
      // lowest count, oldest among ties
      if (ent.valid && (!res_r.vict_found || ent.count < res_r.vict_count ||
          (ent.count == res_r.vict_count && ent.rank > res_r.vict_rank))) begin
        res_nxt.vict_found  = 1'b1;
        res_nxt.vict_idx    = idx;
        res_nxt.vict_count  = ent.count;
        res_nxt.vict_rank   = ent.rank;
        res_nxt.vict_handle = ent.handle;
      end
      if (!ent.valid && !res_r.free_found) begin
        res_nxt.free_found = 1'b1;
        res_nxt.free_idx   = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// File: src/lfu_ctrl.sv
module lfu_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [lfu_pkg::CAP_W-1:0]    cap,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lfu_pkg::KEY_W-1:0]    in_key_tag,
  input  logic                         in_fill_ok,
  input  logic [lfu_pkg::HANDLE_W-1:0] in_fill_handle,
  input  logic [lfu_pkg::SIZE_W-1:0]   in_fill_size,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic                         out_result_ok,
  output logic [lfu_pkg::HANDLE_W-1:0] out_handle,
  output logic [lfu_pkg::SIZE_W-1:0]   out_size,
  output logic                         out_evicted,
  output logic [lfu_pkg::HANDLE_W-1:0] out_evicted_handle,
  output logic [lfu_pkg::IDX_W-1:0]    scan_idx,
  output logic [lfu_pkg::KEY_W-1:0]    scan_key,
  output lfu_pkg::scan_ctl_t           scan_ctl,
  input  lfu_pkg::scan_t               scan_res,
  input  logic [lfu_pkg::VC_W-1:0]     valid_count,
  output lfu_pkg::upd_t                upd
);
  import lfu_pkg::*;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [KEY_W-1:0]    key_r;
  logic                fill_ok_r;
  logic [HANDLE_W-1:0] fill_handle_r;
  logic [SIZE_W-1:0]   fill_size_r;

  logic                out_valid_r, out_valid_nxt;
  logic                hit_r, ok_r, evicted_r;
  logic [HANDLE_W-1:0] handle_r, ev_handle_r;
  logic [SIZE_W-1:0]   size_r;

  logic            accept;
  logic            last_idx;
  logic            out_free;
  logic            do_upd;
  logic            is_fill;
  logic            full;
  logic            take_victim_slot;
  logic [VC_W-1:0] cap_eff;
  int unsigned     cap_i;

  assign accept   = in_valid && in_ready;
  assign last_idx = (idx_r == IDX_W'(ENTRIES - 1));
  assign out_free = !out_valid_r || out_ready;

  // clamp capacity into 1..ENTRIES
  always_comb begin
    cap_i = 32'(cap);
    if (cap_i == 0) begin
      cap_i = 1;
    end else if (cap_i > ENTRIES) begin
      cap_i = ENTRIES;
    end
    cap_eff = VC_W'(cap_i);
  end

  assign is_fill          = !scan_res.found && fill_ok_r;
  assign full             = valid_count >= cap_eff;
  assign take_victim_slot = !scan_res.free_found || scan_res.vict_idx < scan_res.free_idx;

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        if (last_idx) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready      = 1'b0;
    scan_ctl.clr  = 1'b0;
    scan_ctl.step = 1'b0;
    do_upd        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        scan_ctl.clr = in_valid;
      end
      ST_SCAN: begin
        scan_ctl.step = 1'b1;
      end
      ST_UPDATE: begin
        do_upd = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign scan_idx = idx_r;
  assign scan_key = key_r;

  always_comb begin
    upd.en         = do_upd;
    upd.do_hit     = scan_res.found;
    upd.hit_idx    = scan_res.found_idx;
    upd.hit_rank   = scan_res.found_rank;
    upd.do_evict   = is_fill && full && scan_res.vict_found;
    upd.evict_idx  = scan_res.vict_idx;
    upd.evict_rank = scan_res.vict_rank;
    upd.do_insert  = is_fill && (scan_res.free_found || upd.do_evict);
    upd.ins_idx    = (upd.do_evict && take_victim_slot) ? scan_res.vict_idx : scan_res.free_idx;
    upd.ins_key    = key_r;
    upd.ins_handle = fill_handle_r;
    upd.ins_size   = fill_size_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_upd) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the item for the whole pass
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r         <= in_key_tag & TAG_MASK;
      fill_ok_r     <= in_fill_ok;
      fill_handle_r <= in_fill_handle;
      fill_size_r   <= in_fill_size;
    end
  end

  always_ff @(posedge clk) begin
    if (do_upd) begin
      hit_r       <= scan_res.found;
      ok_r        <= scan_res.found || fill_ok_r;
      evicted_r   <= upd.do_evict;
      ev_handle_r <= upd.do_evict ? scan_res.vict_handle : '0;
      if (scan_res.found) begin
        handle_r <= scan_res.found_handle;
        size_r   <= scan_res.found_size;
      end else if (fill_ok_r) begin
        handle_r <= fill_handle_r;
        size_r   <= fill_size_r;
      end else begin
        handle_r <= '0;
        size_r   <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = hit_r;
  assign out_result_ok      = ok_r;
  assign out_handle         = handle_r;
  assign out_size           = size_r;
  assign out_evicted        = evicted_r;
  assign out_evicted_handle = ev_handle_r;

endmodule

// File: src/lfu_cache_lru_tiebreak_unit.sv
// An accepted item makes one pass over all 16 table entries through the shared
// compare unit, then the update cycle, after which out_valid rises.
// No new item is taken during a pass; in_ready is high only between items, and a
// result not yet taken holds the update cycle until out_ready.
// Reset: clears all entry valid bits, the occupancy count and the sequencer;
// the capacity register cap_r returns to 16. No clearing pass: the block is ready at once.
module lfu_cache_lru_tiebreak_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lfu_pkg::KEY_W-1:0]    in_key_tag,
  input  logic                         in_fill_ok,
  input  logic [lfu_pkg::HANDLE_W-1:0] in_fill_handle,
  input  logic [lfu_pkg::SIZE_W-1:0]   in_fill_size,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic                         out_result_ok,
  output logic [lfu_pkg::HANDLE_W-1:0] out_handle,
  output logic [lfu_pkg::SIZE_W-1:0]   out_size,
  output logic                         out_evicted,
  output logic [lfu_pkg::HANDLE_W-1:0] out_evicted_handle
);
  import lfu_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic [IDX_W-1:0] scan_idx;
  logic [KEY_W-1:0] scan_key;
  logic [VC_W-1:0]  valid_count;
  scan_ctl_t        scan_ctl;
  scan_t            scan_res;
  entry_rd_t        rd_entry;
  upd_t             upd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  lfu_store u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_idx      (scan_idx),
    .rd_entry    (rd_entry),
    .upd         (upd),
    .valid_count (valid_count)
  );

  lfu_scan u_scan (
    .clk (clk),
    .ctl (scan_ctl),
    .idx (scan_idx),
    .key (scan_key),
    .ent (rd_entry),
    .res (scan_res)
  );

  lfu_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .cap                (cap_r),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_key_tag         (in_key_tag),
    .in_fill_ok         (in_fill_ok),
    .in_fill_handle     (in_fill_handle),
    .in_fill_size       (in_fill_size),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_result_ok      (out_result_ok),
    .out_handle         (out_handle),
    .out_size           (out_size),
    .out_evicted        (out_evicted),
    .out_evicted_handle (out_evicted_handle),
    .scan_idx           (scan_idx),
    .scan_key           (scan_key),
    .scan_ctl           (scan_ctl),
    .scan_res           (scan_res),
    .valid_count        (valid_count),
    .upd                (upd)
  );

endmodule
